>>> sv/sitrd_pkg.sv
// shared types and constants of the signed integer to radix digits converter
// no dependencies; imported by the controller, the datapath and the top level
`default_nettype none

package sitrd_pkg;

    // operand and digit geometry
    localparam int VALUE_WIDTH = 32;
    localparam int MAX_RADIX   = 16;
    localparam int RADIX_W     = 5;
    localparam int DIGIT_W     = 4;
    localparam int CHAR_W      = 8;
    localparam int TABLE_W     = 64;
    localparam int NUM_BYTES   = VALUE_WIDTH / 8;
    localparam int BYTE_IDX_W  = (NUM_BYTES > 1) ? $clog2(NUM_BYTES) : 1;
    localparam int STORE_IDX_W = $clog2(VALUE_WIDTH);
    localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIX      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARS_HIGH = 2'd2;

    // reset value of the radix register
    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

    // ascii minus sign
    localparam logic [CHAR_W-1:0] MINUS_CODE = 8'h2D;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_DIGITS
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic emit_sign;
        logic emit_digit;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic conv_done;
        logic neg;
        logic last_digit;
        logic out_space;
    } sts_t;

endpackage

`default_nettype wire

>>> sv/sitrd_ctrl.sv
// controller state machine: load, digit extraction, sign and digit emission
// depends on sitrd_pkg for the state type and the command and status structs
`default_nettype none

module sitrd_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire sitrd_pkg::sts_t sts,
    output sitrd_pkg::cmd_t     cmd
);
    import sitrd_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (sts.conv_done)
                begin
                    state_next = sts.neg ? ST_SIGN : ST_DIGITS;
                end
            end
            ST_SIGN:
            begin
                if (sts.out_space)
                begin
                    state_next = ST_DIGITS;
                end
            end
            ST_DIGITS:
            begin
                if (sts.out_space && sts.last_digit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
            end
            ST_SIGN:
            begin
                cmd.emit_sign = sts.out_space;
            end
            ST_DIGITS:
            begin
                cmd.emit_digit = sts.out_space;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // a finished conversion always moves on to emission
    ap_done_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && sts.conv_done)
            |=> (state_reg == ST_SIGN || state_reg == ST_DIGITS))
        else $error("conversion done but emission not started");

    // the final digit frees the input side
    ap_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_digit && sts.last_digit) |=> in_ready)
        else $error("input not ready after last character");

endmodule

`default_nettype wire

>>> sv/sitrd_dp.sv
// datapath: config registers, quotient/remainder registers, byte-wise divider,
// digit store, character lookup and output register; depends on sitrd_pkg
`default_nettype none

module sitrd_dp (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_valid,
    input  wire logic [sitrd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [sitrd_pkg::TABLE_W-1:0]         cfg_data,
    input  wire logic signed [sitrd_pkg::VALUE_WIDTH-1:0] value,
    input  wire logic                                  out_ready,
    output logic                                       out_valid,
    output logic [sitrd_pkg::CHAR_W-1:0]               char_code,
    output logic                                       last_char,
    input  wire sitrd_pkg::cmd_t                       cmd,
    output sitrd_pkg::sts_t                            sts
);
    import sitrd_pkg::*;

    // one restoring division step per bit over a byte, remainder stays below r
    function automatic logic [CHAR_W+DIGIT_W-1:0] div_byte(
        input logic [DIGIT_W-1:0] rem_in,
        input logic [CHAR_W-1:0]  dividend,
        input logic [RADIX_W-1:0] r
    );
        logic [DIGIT_W-1:0] rem_w;
        logic [RADIX_W-1:0] trial;
        logic [CHAR_W-1:0]  quo;
        rem_w = rem_in;
        quo   = '0;
        for (int i = CHAR_W - 1; i >= 0; i--)
        begin
            trial = {rem_w, dividend[i]};
            if (trial >= r)
            begin
                quo[i] = 1'b1;
                trial  = trial - r;
            end
            rem_w = trial[DIGIT_W-1:0];
        end
        return {quo, rem_w};
    endfunction

    // index of the highest nonzero byte, zero for a zero word
    function automatic logic [BYTE_IDX_W-1:0] top_byte(
        input logic [VALUE_WIDTH-1:0] q
    );
        logic [BYTE_IDX_W-1:0] idx;
        idx = '0;
        for (int b = 0; b < NUM_BYTES; b++)
        begin
            if (q[b*CHAR_W +: CHAR_W] != '0)
            begin
                idx = BYTE_IDX_W'(b);
            end
        end
        return idx;
    endfunction

    // configuration registers
    logic [RADIX_W-1:0] radix_reg;
    logic [TABLE_W-1:0] chars_low_reg;
    logic [TABLE_W-1:0] chars_high_reg;

    // conversion state
    logic [VALUE_WIDTH-1:0] q_reg;
    logic [DIGIT_W-1:0]     rem_reg;
    logic [BYTE_IDX_W-1:0]  bi_reg;
    logic [CNT_W-1:0]       n_reg;
    logic                   neg_reg;
    logic [DIGIT_W-1:0]     digit_store_reg [VALUE_WIDTH];

    // output register
    logic                   out_valid_reg;
    logic [CHAR_W-1:0]      char_reg;
    logic                   last_reg;

    // combinational datapath signals
    logic [RADIX_W-1:0]       eff_radix;
    logic                     pow2;
    logic [2:0]               shift_amt;
    logic [DIGIT_W-1:0]       digit_mask;
    logic [VALUE_WIDTH-1:0]   value_u;
    logic [VALUE_WIDTH-1:0]   magnitude;
    logic [CHAR_W+DIGIT_W-1:0] div_out;
    logic [VALUE_WIDTH-1:0]   q_next;
    logic [DIGIT_W-1:0]       rem_next;
    logic [DIGIT_W-1:0]       digit;
    logic                     digit_done;
    logic [CNT_W-1:0]         rd_cnt;
    logic [DIGIT_W-1:0]       rd_digit;
    logic [CHAR_W-1:0]        rd_char;
    logic [TABLE_W-1:0]       table_word;
    logic                     out_space;

    // radix clamped to the supported range
    always_comb
    begin
        eff_radix = radix_reg;
        if (radix_reg < RADIX_W'(2))
        begin
            eff_radix = RADIX_W'(2);
        end
        else if (radix_reg > RADIX_W'(MAX_RADIX))
        begin
            eff_radix = RADIX_W'(MAX_RADIX);
        end
    end

    // power-of-two radix takes a shift per digit
    always_comb
    begin
        pow2      = 1'b1;
        shift_amt = 3'd1;
        case (eff_radix)
            5'd2:    shift_amt = 3'd1;
            5'd4:    shift_amt = 3'd2;
            5'd8:    shift_amt = 3'd3;
            5'd16:   shift_amt = 3'd4;
            default: pow2      = 1'b0;
        endcase
    end

    assign digit_mask = DIGIT_W'(eff_radix - RADIX_W'(1));

    // magnitude of the input, most negative value stays exact unsigned
    assign value_u   = $unsigned(value);
    assign magnitude = value_u[VALUE_WIDTH-1] ? (~value_u + VALUE_WIDTH'(1)) : value_u;

    // one step of the digit extraction
    assign div_out = div_byte(rem_reg, q_reg[bi_reg*CHAR_W +: CHAR_W], eff_radix);

    always_comb
    begin
        q_next     = q_reg;
        rem_next   = rem_reg;
        digit      = '0;
        digit_done = 1'b0;
        if (pow2)
        begin
            q_next     = q_reg >> shift_amt;
            digit      = q_reg[DIGIT_W-1:0] & digit_mask;
            digit_done = 1'b1;
        end
        else
        begin
            for (int b = 0; b < NUM_BYTES; b++)
            begin
                if (BYTE_IDX_W'(b) == bi_reg)
                begin
                    q_next[b*CHAR_W +: CHAR_W] = div_out[CHAR_W+DIGIT_W-1:DIGIT_W];
                end
            end
            rem_next   = div_out[DIGIT_W-1:0];
            digit      = div_out[DIGIT_W-1:0];
            digit_done = (bi_reg == '0);
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg      <= RADIX_RESET;
            chars_low_reg  <= '0;
            chars_high_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_RADIX:      radix_reg      <= cfg_data[RADIX_W-1:0];
                CFG_CHARS_LOW:  chars_low_reg  <= cfg_data;
                CFG_CHARS_HIGH: chars_high_reg <= cfg_data;
                default:        radix_reg      <= radix_reg;
            endcase
        end
    end

    // quotient, remainder, byte pointer, digit count and sign
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg   <= '0;
            rem_reg <= '0;
            bi_reg  <= '0;
            n_reg   <= '0;
            neg_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            q_reg   <= magnitude;
            rem_reg <= '0;
            bi_reg  <= top_byte(magnitude);
            n_reg   <= '0;
            neg_reg <= value_u[VALUE_WIDTH-1];
        end
        else if (cmd.step)
        begin
            q_reg <= q_next;
            if (digit_done)
            begin
                rem_reg <= '0;
                bi_reg  <= top_byte(q_next);
                n_reg   <= n_reg + CNT_W'(1);
            end
            else
            begin
                rem_reg <= rem_next;
                bi_reg  <= bi_reg - BYTE_IDX_W'(1);
            end
        end
        else if (cmd.emit_digit)
        begin
            n_reg <= n_reg - CNT_W'(1);
        end
    end

    // digit store, least significant digit first
    always_ff @(posedge clk)
    begin
        if (cmd.step && digit_done)
        begin
            digit_store_reg[n_reg[STORE_IDX_W-1:0]] <= digit;
        end
    end

    // character lookup for the next digit, most significant first
    assign rd_cnt     = n_reg - CNT_W'(1);
    assign rd_digit   = digit_store_reg[rd_cnt[STORE_IDX_W-1:0]];
    assign table_word = rd_digit[DIGIT_W-1] ? chars_high_reg : chars_low_reg;
    assign rd_char    = table_word[rd_digit[DIGIT_W-2:0]*CHAR_W +: CHAR_W];

    // output register
    assign out_space = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_sign || cmd.emit_digit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_sign)
        begin
            char_reg <= MINUS_CODE;
            last_reg <= 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            char_reg <= rd_char;
            last_reg <= (n_reg == CNT_W'(1));
        end
    end

    assign out_valid = out_valid_reg;
    assign char_code = char_reg;
    assign last_char = last_reg;

    // status to the controller
    assign sts.conv_done  = cmd.step && digit_done
                            && ((q_next == '0) || (n_reg == CNT_W'(VALUE_WIDTH - 1)));
    assign sts.neg        = neg_reg;
    assign sts.last_digit = (n_reg == CNT_W'(1));
    assign sts.out_space  = out_space;

    // a character is only loaded into a free output register
    ap_emit_space: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_sign || cmd.emit_digit) |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten");

    // digit emission never runs past the stored digits
    ap_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_digit |-> (n_reg != '0))
        else $error("digit emitted with empty store");

    // partial remainder stays below the radix
    ap_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> ({1'b0, rem_reg} < eff_radix))
        else $error("remainder out of range");

    // digit store never overflows
    ap_store_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (n_reg < CNT_W'(VALUE_WIDTH)))
        else $error("digit store overflow");

endmodule

`default_nettype wire

>>> sv/signed_int_to_radix_digits.sv
// Converts a signed 32-bit integer into its characters in a configured radix
// (2 to 16), most significant first, with a leading '-' for negative values and
// the final character flagged on last_char. Radix values below 2 act as 2, above
// 16 as 16; digit codes come from the two 64-bit table registers, unchecked.
// Configuration writes (cfg_index 0 radix, 1 digits 0-7, 2 digits 8-15) are
// always taken and must only happen while no conversion is in flight. One value
// is converted at a time: the acceptance cycle, then the digit extraction, then
// one character per cycle while the output is taken. For a power-of-two radix
// each digit is taken with one shift; otherwise each digit comes from stepping
// the byte-wide restoring divider through the significant bytes (1 to 4) of the
// remaining quotient, highest first. The next value is accepted once the last
// character sits in the output register.
// Depends on sitrd_pkg, sitrd_ctrl and sitrd_dp.
`default_nettype none

module signed_int_to_radix_digits (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     cfg_valid,
    output logic                                          cfg_ready,
    input  wire logic [sitrd_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [sitrd_pkg::TABLE_W-1:0]            cfg_data,
    input  wire logic                                     in_valid,
    output logic                                          in_ready,
    input  wire logic signed [sitrd_pkg::VALUE_WIDTH-1:0] value,
    output logic                                          out_valid,
    input  wire logic                                     out_ready,
    output logic [sitrd_pkg::CHAR_W-1:0]                  char_code,
    output logic                                          last_char
);
    import sitrd_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // configuration writes never stall
    assign cfg_ready = 1'b1;

    // sequencing
    sitrd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // arithmetic, storage and output register
    sitrd_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .value     (value),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .char_code (char_code),
        .last_char (last_char),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire
